>>> hdl/stmm_pkg.sv
// stmm_pkg: types, constants and codes of the sparse triplet matrix multiply unit
// no dependencies; used by every module of the block but stmm_ram
`default_nettype none

package stmm_pkg;

  localparam int MAX_TERMS = 1024;
  localparam int MAX_DIM   = 1024;
  localparam int TERM_AW   = $clog2(MAX_TERMS);
  localparam int DIM_AW    = $clog2(MAX_DIM);
  localparam int IDX_W     = 11;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int VAL_W     = 32;

  localparam logic [IDX_W-1:0] DIM_MAX    = IDX_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] TERMS_FULL = CNT_W'(MAX_TERMS);

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND_A = 2'd1,
    FUNC_APPEND_B = 2'd2,
    FUNC_FETCH    = 2'd3
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic [IDX_W-1:0]         entry_row;
    logic [IDX_W-1:0]         entry_col;
    logic signed [VAL_W-1:0]  entry_value;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     found;
    logic                     status;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } triplet_t;

  localparam int TRIP_W = $bits(triplet_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_SC_RD,
    ST_SC_CHK,
    ST_ADV,
    ST_ADV2,
    ST_CLR,
    ST_FILL_A,
    ST_A_CHK,
    ST_FILL_B,
    ST_B_CHK,
    ST_S_RD,
    ST_S_WR
  } state_t;

  typedef struct packed {
    logic clear;
    logic app_a;
    logic app_b;
    logic emit_plain;
    logic plain_status;
    logic emit_found;
    logic emit_none;
    logic scan_init;
    logic scan_next;
    logic scan_hit;
    logic scan_skip;
    logic scan_rd;
    logic row_next;
    logic clr_init;
    logic clr_step;
    logic i_init;
    logic i_next;
    logic a_latch;
    logic k_init;
    logic k_next;
    logic b_latch;
    logic sum_wr;
  } cmd_t;

  typedef struct packed {
    logic a_full;
    logic b_full;
    logic i_end;
    logic k_end;
    logic a_match;
    logic b_match;
    logic clr_end;
    logic row_live;
    logic row_past;
    logic scan_end;
    logic sum_nz;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/stmm_ram.sv
// stmm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module stmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/stmm_ctrl.sv
// stmm_ctrl: sequencing state machine for appends, row fill, clearing pass and scan
// depends on stmm_pkg
`default_nettype none

module stmm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire stmm_pkg::func_t func,
  input  wire stmm_pkg::stat_t st,
  output logic                busy,
  output stmm_pkg::cmd_t      cmd
);

  stmm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != stmm_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      stmm_pkg::ST_IDLE: begin
        if (start) begin
          case (func)
            stmm_pkg::FUNC_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.emit_plain = 1'b1;
            end
            stmm_pkg::FUNC_APPEND_A: begin
              cmd.emit_plain = 1'b1;
              cmd.plain_status = st.a_full;
              cmd.app_a = !st.a_full;
            end
            stmm_pkg::FUNC_APPEND_B: begin
              cmd.emit_plain = 1'b1;
              cmd.plain_status = st.b_full;
              cmd.app_b = !st.b_full;
            end
            default: begin
              state_next = stmm_pkg::ST_TOP;
            end
          endcase
        end
      end
      stmm_pkg::ST_TOP: begin
        if (st.row_live) begin
          cmd.scan_init = 1'b1;
          state_next = stmm_pkg::ST_SC_RD;
        end else begin
          state_next = stmm_pkg::ST_ADV;
        end
      end
      stmm_pkg::ST_SC_RD: begin
        if (st.scan_end) begin
          cmd.scan_skip = 1'b1;
          state_next = stmm_pkg::ST_ADV;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = stmm_pkg::ST_SC_CHK;
        end
      end
      stmm_pkg::ST_SC_CHK: begin
        if (st.sum_nz) begin
          cmd.scan_hit = 1'b1;
          cmd.emit_found = 1'b1;
          state_next = stmm_pkg::ST_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next = stmm_pkg::ST_SC_RD;
        end
      end
      stmm_pkg::ST_ADV: begin
        if (st.row_past) begin
          cmd.emit_none = 1'b1;
          state_next = stmm_pkg::ST_IDLE;
        end else begin
          cmd.row_next = 1'b1;
          state_next = stmm_pkg::ST_ADV2;
        end
      end
      stmm_pkg::ST_ADV2: begin
        if (st.row_past) begin
          cmd.emit_none = 1'b1;
          state_next = stmm_pkg::ST_IDLE;
        end else begin
          cmd.clr_init = 1'b1;
          state_next = stmm_pkg::ST_CLR;
        end
      end
      stmm_pkg::ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_end) begin
          cmd.i_init = 1'b1;
          state_next = stmm_pkg::ST_FILL_A;
        end
      end
      stmm_pkg::ST_FILL_A: begin
        if (st.i_end) begin
          state_next = stmm_pkg::ST_TOP;
        end else begin
          state_next = stmm_pkg::ST_A_CHK;
        end
      end
      stmm_pkg::ST_A_CHK: begin
        if (st.a_match) begin
          cmd.a_latch = 1'b1;
          cmd.k_init = 1'b1;
          state_next = stmm_pkg::ST_FILL_B;
        end else begin
          cmd.i_next = 1'b1;
          state_next = stmm_pkg::ST_FILL_A;
        end
      end
      stmm_pkg::ST_FILL_B: begin
        if (st.k_end) begin
          cmd.i_next = 1'b1;
          state_next = stmm_pkg::ST_FILL_A;
        end else begin
          state_next = stmm_pkg::ST_B_CHK;
        end
      end
      stmm_pkg::ST_B_CHK: begin
        if (st.b_match) begin
          cmd.b_latch = 1'b1;
          state_next = stmm_pkg::ST_S_RD;
        end else begin
          cmd.k_next = 1'b1;
          state_next = stmm_pkg::ST_FILL_B;
        end
      end
      stmm_pkg::ST_S_RD: begin
        state_next = stmm_pkg::ST_S_WR;
      end
      stmm_pkg::ST_S_WR: begin
        cmd.sum_wr = 1'b1;
        cmd.k_next = 1'b1;
        state_next = stmm_pkg::ST_FILL_B;
      end
      default: begin
        state_next = stmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/stmm_dp.sv
// stmm_dp: triplet stores, row accumulator, counters, cursor and result register
// depends on stmm_pkg and stmm_ram
`default_nettype none

module stmm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire stmm_pkg::item_t              item,
  input  wire logic [stmm_pkg::IDX_W-1:0]   a_rows,
  input  wire logic [stmm_pkg::IDX_W-1:0]   b_cols,
  input  wire stmm_pkg::cmd_t               cmd,
  output stmm_pkg::stat_t                   st,
  output logic                              done,
  output stmm_pkg::result_t                 result
);

  logic [stmm_pkg::CNT_W-1:0]   a_count, b_count;
  logic [stmm_pkg::CNT_W-1:0]   idx_i, idx_k;
  logic [stmm_pkg::IDX_W-1:0]   cursor_row, cursor_col;
  logic [stmm_pkg::IDX_W-1:0]   d;
  logic [stmm_pkg::DIM_AW-1:0]  clr_addr;
  logic [stmm_pkg::IDX_W-1:0]   a_col;
  logic [stmm_pkg::VAL_W-1:0]   a_val;
  logic [stmm_pkg::IDX_W-1:0]   b_col;
  logic [stmm_pkg::VAL_W-1:0]   prod;
  logic [stmm_pkg::IDX_W-1:0]   rows, cols;
  logic [stmm_pkg::IDX_W-1:0]   d_m1, bcol_m1;
  stmm_pkg::triplet_t           wr_trip, a_rd, b_rd;
  logic [stmm_pkg::TRIP_W-1:0]  a_rdata, b_rdata;
  logic [stmm_pkg::VAL_W-1:0]   s_rdata, s_wdata;
  logic [stmm_pkg::DIM_AW-1:0]  s_waddr, s_raddr;
  logic                         s_we;

  assign rows = (a_rows > stmm_pkg::DIM_MAX) ? stmm_pkg::DIM_MAX : a_rows;
  assign cols = (b_cols > stmm_pkg::DIM_MAX) ? stmm_pkg::DIM_MAX : b_cols;

  assign wr_trip.row   = item.entry_row;
  assign wr_trip.col   = item.entry_col;
  assign wr_trip.value = item.entry_value;

  assign a_rd = stmm_pkg::triplet_t'(a_rdata);
  assign b_rd = stmm_pkg::triplet_t'(b_rdata);

  stmm_ram #(.WIDTH(stmm_pkg::TRIP_W), .DEPTH(stmm_pkg::MAX_TERMS)) u_a_ram (
    .clk   (clk),
    .we    (cmd.app_a),
    .waddr (a_count[stmm_pkg::TERM_AW-1:0]),
    .wdata (wr_trip),
    .raddr (idx_i[stmm_pkg::TERM_AW-1:0]),
    .rdata (a_rdata)
  );

  stmm_ram #(.WIDTH(stmm_pkg::TRIP_W), .DEPTH(stmm_pkg::MAX_TERMS)) u_b_ram (
    .clk   (clk),
    .we    (cmd.app_b),
    .waddr (b_count[stmm_pkg::TERM_AW-1:0]),
    .wdata (wr_trip),
    .raddr (idx_k[stmm_pkg::TERM_AW-1:0]),
    .rdata (b_rdata)
  );

  assign d_m1    = d - stmm_pkg::IDX_W'(1);
  assign bcol_m1 = b_col - stmm_pkg::IDX_W'(1);
  assign s_we    = cmd.clr_step | cmd.sum_wr;
  assign s_waddr = cmd.clr_step ? clr_addr : bcol_m1[stmm_pkg::DIM_AW-1:0];
  assign s_wdata = cmd.clr_step ? '0 : (s_rdata + prod);
  assign s_raddr = cmd.scan_rd ? d_m1[stmm_pkg::DIM_AW-1:0]
                               : bcol_m1[stmm_pkg::DIM_AW-1:0];

  stmm_ram #(.WIDTH(stmm_pkg::VAL_W), .DEPTH(stmm_pkg::MAX_DIM)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign st.a_full   = (a_count == stmm_pkg::TERMS_FULL);
  assign st.b_full   = (b_count == stmm_pkg::TERMS_FULL);
  assign st.i_end    = (idx_i == a_count);
  assign st.k_end    = (idx_k == b_count);
  assign st.a_match  = (a_rd.row == cursor_row);
  assign st.b_match  = (b_rd.row == a_col) && (b_rd.col != '0)
                       && (b_rd.col <= stmm_pkg::DIM_MAX);
  assign st.clr_end  = (clr_addr == stmm_pkg::DIM_AW'(stmm_pkg::MAX_DIM - 1));
  assign st.row_live = (cursor_row != '0) && (cursor_row <= rows);
  assign st.row_past = (cursor_row > rows);
  assign st.scan_end = (d > cols);
  assign st.sum_nz   = (s_rdata != '0);

  // counters and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      a_count    <= '0;
      b_count    <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.emit_plain | cmd.emit_found | cmd.emit_none;
      if (cmd.clear) begin
        a_count    <= '0;
        b_count    <= '0;
        cursor_row <= '0;
        cursor_col <= '0;
      end
      if (cmd.app_a) begin
        a_count <= a_count + stmm_pkg::CNT_W'(1);
      end
      if (cmd.app_b) begin
        b_count <= b_count + stmm_pkg::CNT_W'(1);
      end
      if (cmd.scan_hit) begin
        cursor_col <= d;
      end
      if (cmd.scan_skip) begin
        cursor_col <= cols;
      end
      if (cmd.row_next) begin
        cursor_row <= cursor_row + stmm_pkg::IDX_W'(1);
        cursor_col <= '0;
      end
    end
  end

  // fill and scan working registers
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      d <= cursor_col + stmm_pkg::IDX_W'(1);
    end else if (cmd.scan_next) begin
      d <= d + stmm_pkg::IDX_W'(1);
    end
    if (cmd.clr_init) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + stmm_pkg::DIM_AW'(1);
    end
    if (cmd.i_init) begin
      idx_i <= '0;
    end else if (cmd.i_next) begin
      idx_i <= idx_i + stmm_pkg::CNT_W'(1);
    end
    if (cmd.k_init) begin
      idx_k <= '0;
    end else if (cmd.k_next) begin
      idx_k <= idx_k + stmm_pkg::CNT_W'(1);
    end
    if (cmd.a_latch) begin
      a_col <= a_rd.col;
      a_val <= a_rd.value;
    end
    if (cmd.b_latch) begin
      b_col <= b_rd.col;
      prod  <= stmm_pkg::VAL_W'(a_val * b_rd.value);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_found) begin
      result.out_row   <= cursor_row;
      result.out_col   <= d;
      result.out_value <= s_rdata;
      result.found     <= 1'b1;
      result.status    <= 1'b0;
    end else if (cmd.emit_plain | cmd.emit_none) begin
      result.out_row   <= '0;
      result.out_col   <= '0;
      result.out_value <= '0;
      result.found     <= 1'b0;
      result.status    <= cmd.emit_plain & cmd.plain_status;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sparse_triplet_matrix_multiply_unit.sv
// sparse_triplet_matrix_multiply_unit: top level with apb register port
// depends on stmm_pkg, stmm_ctrl, stmm_dp
`default_nettype none

// Multiplies two sparse matrices stored as (row, col, value) triplets. Clear
// and append items may follow back to back; their result beat appears on the
// cycle after acceptance. A fetch holds busy while it scans the columns of the
// current row and, for each row entered, runs a clearing pass over all 1024
// entries of the row accumulator, walks the A triplets and, for each A triplet
// in the row, the B triplets, and reads and writes the accumulator for each
// contributing pair. Every item gives exactly one result beat on done, which
// lasts one cycle and cannot be stalled by the receiver.
module sparse_triplet_matrix_multiply_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire stmm_pkg::item_t   item,
  output logic                   done,
  output stmm_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [stmm_pkg::IDX_W-1:0] a_rows, b_cols;
  logic                       accept;
  stmm_pkg::cmd_t             cmd;
  stmm_pkg::stat_t            st;

  assign pready = 1'b1;
  assign accept = start & !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= stmm_pkg::IDX_W'(1);
      b_cols <= stmm_pkg::IDX_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        b_cols <= pwdata[stmm_pkg::IDX_W-1:0];
      end else begin
        a_rows <= pwdata[stmm_pkg::IDX_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {21'd0, b_cols} : {21'd0, a_rows};

  stmm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .func  (item.func),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  stmm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .a_rows (a_rows),
    .b_cols (b_cols),
    .cmd    (cmd),
    .st     (st),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

>>> dv/sparse_triplet_matrix_multiply_unit_chk.sv
// sparse_triplet_matrix_multiply_unit_chk: watches the item, result and apb
// channels, predicts each result beat and compares it; depends on stmm_pkg
`default_nettype none

module sparse_triplet_matrix_multiply_unit_chk (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire stmm_pkg::item_t   item,
  input  wire logic              done,
  input  wire stmm_pkg::result_t result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic [31:0]       prdata,
  input  wire logic              pready,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_A_ROWS = 3'd0;
  localparam logic [2:0] ADDR_B_COLS = 3'd4;

  stmm_pkg::triplet_t a_mem [stmm_pkg::MAX_TERMS];
  stmm_pkg::triplet_t b_mem [stmm_pkg::MAX_TERMS];
  logic [31:0] sums [stmm_pkg::MAX_DIM+1];
  int unsigned a_cnt, b_cnt, cur_row, cur_col;
  logic [10:0] rows_reg, cols_reg;
  stmm_pkg::result_t expected_beats [$];

  assign outstanding = expected_beats.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp_dim(input logic [10:0] v);
    return (v > stmm_pkg::MAX_DIM) ? stmm_pkg::MAX_DIM : v;
  endfunction

  function automatic void load_row(input int unsigned r);
    int unsigned c;
    for (int d = 0; d <= stmm_pkg::MAX_DIM; d++) sums[d] = '0;
    for (int i = 0; i < a_cnt; i++) begin
      if (a_mem[i].row != r) continue;
      for (int k = 0; k < b_cnt; k++) begin
        c = b_mem[k].col;
        if (b_mem[k].row != a_mem[i].col || c == 0 || c > stmm_pkg::MAX_DIM) continue;
        sums[c] = sums[c] + a_mem[i].value * b_mem[k].value;
      end
    end
  endfunction

  function automatic stmm_pkg::result_t product_step(input stmm_pkg::item_t it);
    stmm_pkg::result_t r;
    int unsigned nrows, ncols;
    bit hit;
    r = '0;
    nrows = clamp_dim(rows_reg);
    ncols = clamp_dim(cols_reg);
    case (it.func)
      stmm_pkg::FUNC_CLEAR: begin
        a_cnt = 0;
        b_cnt = 0;
        cur_row = 0;
        cur_col = 0;
      end
      stmm_pkg::FUNC_APPEND_A: begin
        if (a_cnt >= stmm_pkg::MAX_TERMS) r.status = 1'b1;
        else begin
          a_mem[a_cnt] = '{it.entry_row, it.entry_col, it.entry_value};
          a_cnt++;
        end
      end
      stmm_pkg::FUNC_APPEND_B: begin
        if (b_cnt >= stmm_pkg::MAX_TERMS) r.status = 1'b1;
        else begin
          b_mem[b_cnt] = '{it.entry_row, it.entry_col, it.entry_value};
          b_cnt++;
        end
      end
      default: begin
        hit = 0;
        while (!hit) begin
          if (cur_row >= 1 && cur_row <= nrows) begin
            for (int unsigned d = cur_col + 1; d <= ncols; d++) begin
              if (sums[d] != 0) begin
                hit = 1;
                cur_col = d;
                r.out_row = cur_row[10:0];
                r.out_col = d[10:0];
                r.out_value = sums[d];
                r.found = 1'b1;
                break;
              end
            end
            if (!hit) cur_col = ncols;
          end
          if (!hit) begin
            if (cur_row > nrows) break;
            cur_row++;
            cur_col = 0;
            if (cur_row > nrows) break;
            load_row(cur_row);
          end
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    mismatches = 0;
    a_cnt = 0;
    b_cnt = 0;
    cur_row = 0;
    cur_col = 0;
    rows_reg = 11'd1;
    cols_reg = 11'd1;
  end

  always @(posedge clk) begin
    stmm_pkg::result_t want;
    logic [31:0] reg_val;
    if (!rst) begin
      if (done) begin
        if (expected_beats.size() == 0) begin
          report($sformatf("result beat with none expected: %p", result));
        end else begin
          want = expected_beats.pop_front();
          if (result.out_row !== want.out_row)
            report($sformatf("out_row %0d, want %0d", result.out_row, want.out_row));
          if (result.out_col !== want.out_col)
            report($sformatf("out_col %0d, want %0d", result.out_col, want.out_col));
          if (result.out_value !== want.out_value)
            report($sformatf("out_value %h, want %h", result.out_value, want.out_value));
          if (result.found !== want.found)
            report($sformatf("found %b, want %b", result.found, want.found));
          if (result.status !== want.status)
            report($sformatf("status %b, want %b", result.status, want.status));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_A_ROWS) rows_reg = pwdata[10:0];
          else if (paddr == ADDR_B_COLS) cols_reg = pwdata[10:0];
        end else if (paddr == ADDR_A_ROWS || paddr == ADDR_B_COLS) begin
          reg_val = {21'd0, (paddr == ADDR_A_ROWS) ? rows_reg : cols_reg};
          if (prdata !== reg_val)
            report($sformatf("register read at %0d gave %h, want %h", paddr, prdata,
                             reg_val));
        end
      end
      if (start && !busy) expected_beats.push_back(product_step(item));
    end
  end

endmodule

`default_nettype wire

>>> dv/sparse_triplet_matrix_multiply_unit_tb.sv
// sparse_triplet_matrix_multiply_unit_tb: directed and random stimulus for the
// sparse triplet matrix multiply unit; depends on stmm_pkg, dut and checker
`default_nettype none

module sparse_triplet_matrix_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [2:0] ADDR_A_ROWS = 3'd0;
  localparam logic [2:0] ADDR_B_COLS = 3'd4;

  logic clk, rst, start, busy, done;
  stmm_pkg::item_t item;
  stmm_pkg::result_t result;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  int mismatches, outstanding;
  int cycles = 0;
  int unsigned rows_now, cols_now;

  sparse_triplet_matrix_multiply_unit dut (.*);

  sparse_triplet_matrix_multiply_unit_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("sparse_triplet_matrix_multiply_unit_tb failed");
      $finish;
    end
  end

  task automatic send(input stmm_pkg::func_t f, input logic [10:0] r,
                      input logic [10:0] c, input logic [31:0] v);
    @(negedge clk);
    start = 1'b1;
    item = '{f, r, c, v};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(posedge clk);
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return $urandom_range(0, 9) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    pause(1);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_dims(input logic [10:0] r, input logic [10:0] c);
    drain();
    apb(1'b1, ADDR_A_ROWS, {21'd0, r});
    apb(1'b1, ADDR_B_COLS, {21'd0, c});
    apb(1'b0, ADDR_A_ROWS, '0);
    apb(1'b0, ADDR_B_COLS, '0);
    rows_now = (r > stmm_pkg::MAX_DIM) ? stmm_pkg::MAX_DIM : r;
    cols_now = (c > stmm_pkg::MAX_DIM) ? stmm_pkg::MAX_DIM : c;
  endtask

  initial begin
    int issued, phase_left;
    int unsigned p;
    logic [10:0] r, c;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_now = 1;
    cols_now = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset dims, nothing stored yet
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_APPEND_A, 11'd1, 11'd1, 32'h7fff_ffff);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1, 11'd1, 32'h7fff_ffff);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1, 11'd0, 32'd5);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1, 11'h7ff, 32'd5);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_CLEAR, 11'h7ff, 11'h7ff, 32'hffff_ffff);
    set_dims(11'd3, 11'd4);
    send(stmm_pkg::FUNC_APPEND_A, 11'd2, 11'd3, 32'h8000_0000);
    send(stmm_pkg::FUNC_APPEND_A, 11'd2, 11'd3, 32'h8000_0000);
    send(stmm_pkg::FUNC_APPEND_B, 11'd3, 11'd4, 32'd1);
    send(stmm_pkg::FUNC_APPEND_A, 11'd3, 11'd1, 32'd6);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1, 11'd2, 32'hffff_fffd);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1, 11'd4, 32'd2);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    set_dims(11'd0, 11'd4);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_CLEAR, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    // largest dims: only stop in row one, then clear before the long walk
    set_dims(11'd1024, 11'd1024);
    send(stmm_pkg::FUNC_CLEAR, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_APPEND_A, 11'd1, 11'd1024, 32'd3);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1024, 11'd1024, 32'd7);
    send(stmm_pkg::FUNC_APPEND_B, 11'd1024, 11'd1, 32'hffff_ffff);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_CLEAR, 11'd0, 11'd0, 32'd0);
    set_dims(11'h7ff, 11'h7ff);
    send(stmm_pkg::FUNC_APPEND_A, 11'd1, 11'd2, 32'd1);
    send(stmm_pkg::FUNC_APPEND_B, 11'd2, 11'd1000, 32'd1);
    send(stmm_pkg::FUNC_FETCH, 11'd0, 11'd0, 32'd0);
    send(stmm_pkg::FUNC_CLEAR, 11'd0, 11'd0, 32'd0);

    issued = 0;
    phase_left = 0;
    while (issued < 990) begin
      if (phase_left == 0) begin
        p = $urandom_range(0, 9);
        if (p == 0) set_dims(11'($urandom_range(0, 15)), 11'($urandom_range(1, 2)));
        else set_dims(11'($urandom_range(1, 6)), 11'($urandom_range(1, 8)));
        if ($urandom_range(0, 9) < 8)
          send(stmm_pkg::FUNC_CLEAR, 11'($urandom), 11'($urandom), $urandom);
        phase_left = $urandom_range(20, 60);
      end
      p = $urandom_range(0, 99);
      r = 11'($urandom_range(1, rows_now + 1));
      if (p < 8) begin
        send(stmm_pkg::func_t'($urandom_range(0, 3)), 11'($urandom), 11'($urandom),
             $urandom);
      end else if (p < 42) begin
        send(stmm_pkg::FUNC_APPEND_A, r, 11'($urandom_range(1, 4)), pick_value());
      end else if (p < 76) begin
        c = ($urandom_range(0, 15) == 0) ? 11'($urandom)
                                         : 11'($urandom_range(0, cols_now + 1));
        send(stmm_pkg::FUNC_APPEND_B, 11'($urandom_range(1, 4)), c, pick_value());
      end else if (p < 97) begin
        send(stmm_pkg::FUNC_FETCH, 11'($urandom), 11'($urandom), $urandom);
      end else begin
        send(stmm_pkg::FUNC_CLEAR, 11'($urandom), 11'($urandom), $urandom);
      end
      issued++;
      phase_left--;
      if ($urandom_range(0, 3) != 0) pause(gap_len());
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("sparse_triplet_matrix_multiply_unit_tb passed");
    end else begin
      $display("sparse_triplet_matrix_multiply_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/stmm_pkg.sv
hdl/stmm_ram.sv
hdl/stmm_ctrl.sv
hdl/stmm_dp.sv
hdl/sparse_triplet_matrix_multiply_unit.sv
dv/sparse_triplet_matrix_multiply_unit_chk.sv
dv/sparse_triplet_matrix_multiply_unit_tb.sv
